[rtl/lz77ld_pkg.sv]
// Shared constants, status codes and DEFLATE length/distance tables for the LZ77 expander.
package lz77ld_pkg;

  localparam int WindowBytesDef    = 32768;
  localparam int BytesPerResultDef = 8;

  localparam int SymW    = 9;
  localparam int LexW    = 5;
  localparam int DsymW   = 5;
  localparam int DexW    = 13;
  localparam int DataW   = 64;
  localparam int CountW  = 4;
  localparam int StatusW = 3;
  localparam int LenW    = 9;
  localparam int DistW   = 16;

  localparam logic [SymW-1:0]  SymEnd      = 9'd256;
  localparam logic [SymW-1:0]  SymLenFirst = 9'd257;
  localparam logic [SymW-1:0]  SymLenLast  = 9'd285;
  localparam logic [DsymW-1:0] DistCodes   = 5'd30;

  localparam logic [StatusW-1:0] StOk      = 3'd0;
  localparam logic [StatusW-1:0] StEob     = 3'd1;
  localparam logic [StatusW-1:0] StBadLen  = 3'd2;
  localparam logic [StatusW-1:0] StBadDist = 3'd3;
  localparam logic [StatusW-1:0] StFar     = 3'd4;

  function automatic logic [LenW-1:0] len_base(input logic [4:0] idx);
    logic [LenW-1:0] r;
    unique case (idx)
      5'd0: r = 9'd3;      5'd1: r = 9'd4;      5'd2: r = 9'd5;      5'd3: r = 9'd6;
      5'd4: r = 9'd7;      5'd5: r = 9'd8;      5'd6: r = 9'd9;      5'd7: r = 9'd10;
      5'd8: r = 9'd11;     5'd9: r = 9'd13;     5'd10: r = 9'd15;    5'd11: r = 9'd17;
      5'd12: r = 9'd19;    5'd13: r = 9'd23;    5'd14: r = 9'd27;    5'd15: r = 9'd31;
      5'd16: r = 9'd35;    5'd17: r = 9'd43;    5'd18: r = 9'd51;    5'd19: r = 9'd59;
      5'd20: r = 9'd67;    5'd21: r = 9'd83;    5'd22: r = 9'd99;    5'd23: r = 9'd115;
      5'd24: r = 9'd131;   5'd25: r = 9'd163;   5'd26: r = 9'd195;   5'd27: r = 9'd227;
      5'd28: r = 9'd258;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [LexW-1:0] len_mask(input logic [4:0] idx);
    logic [LexW-1:0] r;
    if (idx < 5'd8 || idx == 5'd28) begin
      r = 5'h00;
    end else if (idx < 5'd12) begin
      r = 5'h01;
    end else if (idx < 5'd16) begin
      r = 5'h03;
    end else if (idx < 5'd20) begin
      r = 5'h07;
    end else if (idx < 5'd24) begin
      r = 5'h0f;
    end else begin
      r = 5'h1f;
    end
    return r;
  endfunction

  function automatic logic [DistW-1:0] dist_base(input logic [DsymW-1:0] code);
    logic [DistW-1:0] r;
    unique case (code)
      5'd0: r = 16'd1;       5'd1: r = 16'd2;       5'd2: r = 16'd3;
      5'd3: r = 16'd4;       5'd4: r = 16'd5;       5'd5: r = 16'd7;
      5'd6: r = 16'd9;       5'd7: r = 16'd13;      5'd8: r = 16'd17;
      5'd9: r = 16'd25;      5'd10: r = 16'd33;     5'd11: r = 16'd49;
      5'd12: r = 16'd65;     5'd13: r = 16'd97;     5'd14: r = 16'd129;
      5'd15: r = 16'd193;    5'd16: r = 16'd257;    5'd17: r = 16'd385;
      5'd18: r = 16'd513;    5'd19: r = 16'd769;    5'd20: r = 16'd1025;
      5'd21: r = 16'd1537;   5'd22: r = 16'd2049;   5'd23: r = 16'd3073;
      5'd24: r = 16'd4097;   5'd25: r = 16'd6145;   5'd26: r = 16'd8193;
      5'd27: r = 16'd12289;  5'd28: r = 16'd16385;  5'd29: r = 16'd24577;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DexW-1:0] dist_mask(input logic [DsymW-1:0] code);
    logic [3:0] nbits;
    logic [DexW-1:0] r;
    nbits = (code < 5'd4) ? 4'd0 : 4'(code[4:1] - 4'd1);
    r = DexW'((14'd1 << nbits) - 14'd1);
    return r;
  endfunction

endpackage

[rtl/lz77ld_if.sv]
// Valid/ready channel interfaces for tokens in and expanded result words out.
interface lz77ld_tok_if;
  logic                          valid;
  logic                          ready;
  logic                          new_stream;
  logic [lz77ld_pkg::SymW-1:0]   symbol;
  logic [lz77ld_pkg::LexW-1:0]   length_extra;
  logic [lz77ld_pkg::DsymW-1:0]  distance_symbol;
  logic [lz77ld_pkg::DexW-1:0]   distance_extra;

  modport source (
    output valid, new_stream, symbol, length_extra, distance_symbol, distance_extra,
    input  ready
  );
  modport sink (
    input  valid, new_stream, symbol, length_extra, distance_symbol, distance_extra,
    output ready
  );
endinterface

interface lz77ld_res_if;
  logic                            valid;
  logic                            ready;
  logic [lz77ld_pkg::DataW-1:0]    data;
  logic [lz77ld_pkg::CountW-1:0]   byte_count;
  logic [lz77ld_pkg::StatusW-1:0]  status;
  logic                            last;

  modport source (
    output valid, data, byte_count, status, last,
    input  ready
  );
  modport sink (
    input  valid, data, byte_count, status, last,
    output ready
  );
endinterface

[rtl/lz77ld_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lz77ld_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/lz77_length_distance_expander_core.sv]
// Top level of the DEFLATE LZ77 length/distance expander.
// Takes one pre-decoded token at a time and returns its bytes in words of up to
// BYTES_PER_RESULT bytes. A literal, end of block or bad code token gives its single
// result through S_CALC and S_FLUSH, and a distance that is too far gives it through
// S_CALC, S_CHK and S_FLUSH; from S_FLUSH the core goes back to S_IDLE for the next
// token. A back-reference spends S_CALC on table lookup and S_CHK on the distance
// check, then reads its bytes one at a time in S_WR through the single read port of
// the history RAM, plus S_RD (read issue) and S_FLUSH (word hand-off) per output word.
// The token port is ready only while no token is being worked on; a finished word
// waits in the output register, so the next token can be taken meanwhile. The
// history RAM needs no clearing pass, as it is read only at bytes the stream wrote.
module lz77_length_distance_expander_core #(
  parameter int WINDOW_BYTES     = lz77ld_pkg::WindowBytesDef,
  parameter int BYTES_PER_RESULT = lz77ld_pkg::BytesPerResultDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lz77ld_tok_if.sink   tok_i,
  lz77ld_res_if.source res_o
);

  localparam int AddrW = $clog2(WINDOW_BYTES);
  localparam int PcW   = $clog2(WINDOW_BYTES + 1);
  localparam int SrcW  = 17;
  localparam int FillW = $clog2(BYTES_PER_RESULT + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CALC  = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]                      state_q, state_d;
  logic [lz77ld_pkg::SymW-1:0]     sym_q, sym_d;
  logic [lz77ld_pkg::LexW-1:0]     lex_q, lex_d;
  logic [lz77ld_pkg::DsymW-1:0]    dsym_q, dsym_d;
  logic [lz77ld_pkg::DexW-1:0]     dex_q, dex_d;
  logic [lz77ld_pkg::LenW-1:0]     rem_q, rem_d;
  logic [lz77ld_pkg::DistW-1:0]    dist_q, dist_d;
  logic [AddrW-1:0]                wp_q, wp_d;
  logic [PcW-1:0]                  pc_q, pc_d;
  logic [AddrW-1:0]                src_q, src_d;
  logic [lz77ld_pkg::DataW-1:0]    word_q, word_d;
  logic [FillW-1:0]                fill_q, fill_d;
  logic [7:0]                      prev_q, prev_d;
  logic                            first_q, first_d;
  logic [lz77ld_pkg::StatusW-1:0]  status_q, status_d;

  logic                            out_valid_q, out_valid_d;
  logic [lz77ld_pkg::DataW-1:0]    out_data_q, out_data_d;
  logic [lz77ld_pkg::CountW-1:0]   out_count_q, out_count_d;
  logic [lz77ld_pkg::StatusW-1:0]  out_status_q, out_status_d;
  logic                            out_last_q, out_last_d;

  logic                            ram_we, ram_re;
  logic [AddrW-1:0]                ram_raddr;
  logic [7:0]                      ram_wdata, ram_rdata;

  logic [4:0]                      len_idx;
  logic [lz77ld_pkg::LenW-1:0]     len_calc;
  logic [lz77ld_pkg::DistW-1:0]    dist_calc;
  logic [AddrW-1:0]                wp_inc, src_inc, src_start;
  logic [PcW-1:0]                  pc_sat;
  logic [SrcW-1:0]                 wp_ext, dist_ext, src_diff;
  logic [7:0]                      byte_c;

  assign len_idx   = 5'(sym_q - lz77ld_pkg::SymLenFirst);
  assign len_calc  = lz77ld_pkg::len_base(len_idx)
                   + lz77ld_pkg::LenW'(lex_q & lz77ld_pkg::len_mask(len_idx));
  assign dist_calc = lz77ld_pkg::dist_base(dsym_q)
                   + lz77ld_pkg::DistW'(dex_q & lz77ld_pkg::dist_mask(dsym_q));

  assign wp_inc  = (wp_q == AddrW'(WINDOW_BYTES - 1)) ? '0 : wp_q + AddrW'(1);
  assign src_inc = (src_q == AddrW'(WINDOW_BYTES - 1)) ? '0 : src_q + AddrW'(1);
  assign pc_sat  = (pc_q == PcW'(WINDOW_BYTES)) ? pc_q : pc_q + PcW'(1);

  assign wp_ext    = SrcW'(wp_q);
  assign dist_ext  = SrcW'(dist_q);
  assign src_diff  = (wp_ext >= dist_ext) ? wp_ext - dist_ext
                                          : wp_ext + SrcW'(WINDOW_BYTES) - dist_ext;
  assign src_start = src_diff[AddrW-1:0];

  assign byte_c = (dist_q == lz77ld_pkg::DistW'(1) && !first_q) ? prev_q : ram_rdata;

  assign tok_i.ready      = (state_q == S_IDLE);
  assign res_o.valid      = out_valid_q;
  assign res_o.data       = out_data_q;
  assign res_o.byte_count = out_count_q;
  assign res_o.status     = out_status_q;
  assign res_o.last       = out_last_q;

  always_comb begin
    state_d      = state_q;
    sym_d        = sym_q;
    lex_d        = lex_q;
    dsym_d       = dsym_q;
    dex_d        = dex_q;
    rem_d        = rem_q;
    dist_d       = dist_q;
    wp_d         = wp_q;
    pc_d         = pc_q;
    src_d        = src_q;
    word_d       = word_q;
    fill_d       = fill_q;
    prev_d       = prev_q;
    first_d      = first_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_data_d   = out_data_q;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = src_q;
    ram_wdata    = byte_c;

    unique case (state_q)
      S_IDLE: begin
        if (tok_i.valid) begin
          sym_d  = tok_i.symbol;
          lex_d  = tok_i.length_extra;
          dsym_d = tok_i.distance_symbol;
          dex_d  = tok_i.distance_extra;
          if (tok_i.new_stream) begin
            pc_d = '0;
          end
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        word_d   = '0;
        fill_d   = '0;
        rem_d    = '0;
        status_d = lz77ld_pkg::StOk;
        state_d  = S_FLUSH;
        if (sym_q < lz77ld_pkg::SymEnd) begin
          ram_we    = 1'b1;
          ram_wdata = sym_q[7:0];
          wp_d      = wp_inc;
          pc_d      = pc_sat;
          word_d    = lz77ld_pkg::DataW'(sym_q[7:0]);
          fill_d    = FillW'(1);
        end else if (sym_q == lz77ld_pkg::SymEnd) begin
          status_d = lz77ld_pkg::StEob;
        end else if (sym_q > lz77ld_pkg::SymLenLast) begin
          status_d = lz77ld_pkg::StBadLen;
        end else if (dsym_q >= lz77ld_pkg::DistCodes) begin
          status_d = lz77ld_pkg::StBadDist;
        end else begin
          rem_d   = len_calc;
          dist_d  = dist_calc;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (dist_ext > SrcW'(pc_q)) begin
          status_d = lz77ld_pkg::StFar;
          rem_d    = '0;
          state_d  = S_FLUSH;
        end else begin
          src_d   = src_start;
          first_d = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        ram_we  = 1'b1;
        wp_d    = wp_inc;
        pc_d    = pc_sat;
        src_d   = src_inc;
        prev_d  = byte_c;
        first_d = 1'b0;
        for (int j = 0; j < BYTES_PER_RESULT; j++) begin
          if (fill_q == FillW'(j)) begin
            word_d[8*j +: 8] = byte_c;
          end
        end
        fill_d = fill_q + FillW'(1);
        rem_d  = rem_q - lz77ld_pkg::LenW'(1);
        if (rem_q != lz77ld_pkg::LenW'(1) && fill_q != FillW'(BYTES_PER_RESULT - 1)) begin
          ram_re    = 1'b1;
          ram_raddr = src_inc;
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d  = 1'b1;
          out_data_d   = word_q;
          out_count_d  = lz77ld_pkg::CountW'(fill_q);
          out_status_d = status_q;
          out_last_d   = (rem_q == '0);
          word_d       = '0;
          fill_d       = '0;
          state_d      = (rem_q == '0) ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  lz77ld_ram #(
    .Width (8),
    .Depth (WINDOW_BYTES)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q        <= sym_d;
    lex_q        <= lex_d;
    dsym_q       <= dsym_d;
    dex_q        <= dex_d;
    rem_q        <= rem_d;
    dist_q       <= dist_d;
    src_q        <= src_d;
    word_q       <= word_d;
    fill_q       <= fill_d;
    prev_q       <= prev_d;
    first_q      <= first_d;
    status_q     <= status_d;
    out_data_q   <= out_data_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

endmodule
